>>> design/bnat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bus node address table package
// Shared widths, codes, item types and memory request types.
// ----------------------------------------------------------------------------
package bnat_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int ID_W            = 8;
    localparam int SER_W           = 32;
    localparam int PORT_W          = 2;
    localparam int CNT_W           = 9;
    localparam int ACT_W           = 3;
    localparam int ST_W            = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int ID_COUNT        = 256;

    localparam logic [ACT_W-1:0] ACT_REPORT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_IDLE_ID = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MSEARCH = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MCHANGE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REINIT  = 3'd5;

    localparam logic [ST_W-1:0] ST_NONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [ST_W-1:0] ST_CONFLICT = 3'd2;
    localparam logic [ST_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
    localparam logic [ST_W-1:0] ST_REFUSED  = 3'd5;
    localparam logic [ST_W-1:0] ST_NO_FREE  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_PNP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SER = 2'd2;

    localparam logic [ID_W-1:0] ID_NONE    = 8'hff;
    localparam logic [ID_W-1:0] ID_LAST    = 8'd254;
    localparam logic [ID_W-1:0] ID_FIRST   = 8'd1;
    localparam logic [ID_W-1:0] ID_BCAST   = 8'd255;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   node_id;
        logic [SER_W-1:0]  serial_no;
        logic [PORT_W-1:0] port;
        logic [ID_W-1:0]   entry_index;
        logic [ID_W-1:0]   target_id;
        logic              search_up;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  result_id;
        logic [CNT_W-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   node_id;
        logic [SER_W-1:0]  serial;
        logic [PORT_W-1:0] port;
    } entry_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic [1:0]      wdata;
        logic [ID_W-1:0] raddr;
    } map_req_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic            wdata;
        logic [ID_W-1:0] raddr;
    } tab_req_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        entry_t          wdata;
        logic [ID_W-1:0] raddr;
    } ent_req_t;

endpackage
`default_nettype wire

>>> design/bnat_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bus node address table memory
// Simple dual-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module bnat_ram #(
    parameter int DW    = 2,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> design/bnat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bus node address table sequencer
// Walks the bitmap, entry and scratch memories for each action.
// ----------------------------------------------------------------------------
module bnat_ctrl #(
    parameter int TABLE_DEPTH = bnat_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire bnat_pkg::in_item_t                    in_item,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output bnat_pkg::out_item_t                        out_item,
    input  wire logic                                  cfg_valid,
    input  wire logic [bnat_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bnat_pkg::CFG_DATA_W-1:0]       cfg_data,
    output bnat_pkg::map_req_t                         map_req,
    input  wire logic [1:0]                            map_rdata,
    output bnat_pkg::tab_req_t                         tab_req,
    input  wire logic                                  tab_rdata,
    output bnat_pkg::ent_req_t                         ent_req,
    input  wire bnat_pkg::entry_t                      ent_rdata
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RPT_MRD = 5'd1;
    localparam logic [4:0] S_RPT_MCK = 5'd2;
    localparam logic [4:0] S_RPT_ERD = 5'd3;
    localparam logic [4:0] S_RPT_ECK = 5'd4;
    localparam logic [4:0] S_RM_ID   = 5'd5;
    localparam logic [4:0] S_DROP    = 5'd6;
    localparam logic [4:0] S_SH_RD   = 5'd7;
    localparam logic [4:0] S_SH_WR   = 5'd8;
    localparam logic [4:0] S_IDL_RD  = 5'd9;
    localparam logic [4:0] S_IDL_CK  = 5'd10;
    localparam logic [4:0] S_TCLR    = 5'd11;
    localparam logic [4:0] S_TMK_RD  = 5'd12;
    localparam logic [4:0] S_TMK_WR  = 5'd13;
    localparam logic [4:0] S_CND_RD  = 5'd14;
    localparam logic [4:0] S_CND_CK  = 5'd15;
    localparam logic [4:0] S_MC_RD1  = 5'd16;
    localparam logic [4:0] S_MC_WR1  = 5'd17;
    localparam logic [4:0] S_MC_RD2  = 5'd18;
    localparam logic [4:0] S_MC_WR2  = 5'd19;
    localparam logic [4:0] S_MCLR    = 5'd20;
    localparam logic [4:0] S_MK0     = 5'd21;
    localparam logic [4:0] S_MK_RD   = 5'd22;
    localparam logic [4:0] S_MK_WR   = 5'd23;
    localparam logic [4:0] S_DONE    = 5'd24;

    localparam logic [bnat_pkg::CNT_W-1:0] DEPTH_CNT = bnat_pkg::CNT_W'(TABLE_DEPTH);
    localparam logic [bnat_pkg::CNT_W-1:0] LAST_ID_CNT = bnat_pkg::CNT_W'(bnat_pkg::ID_COUNT - 1);
    localparam logic [bnat_pkg::CNT_W-1:0] CAND_LAST = bnat_pkg::CNT_W'(bnat_pkg::ID_COUNT);

    logic [4:0]                     state_reg, state_next;
    logic [bnat_pkg::CNT_W-1:0]     k_reg, k_next;
    logic [bnat_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [bnat_pkg::CNT_W-1:0]     vc_reg, vc_next;
    logic [bnat_pkg::ID_W-1:0]      cand_reg, cand_next;
    logic [bnat_pkg::ID_W-1:0]      drop_id_reg, drop_id_next;
    bnat_pkg::in_item_t             item_reg, item_next;
    logic [bnat_pkg::ST_W-1:0]      status_reg, status_next;
    logic [bnat_pkg::ID_W-1:0]      rid_reg, rid_next;
    logic [bnat_pkg::ID_W-1:0]      e0_id_reg, e0_id_next;
    logic [bnat_pkg::SER_W-1:0]     e0_ser_reg, e0_ser_next;
    logic                           pnp_reg, pnp_next;
    logic [bnat_pkg::ID_W-1:0]      lid_reg, lid_next;
    logic [bnat_pkg::SER_W-1:0]     lser_reg, lser_next;
    logic                           boot_reg, boot_next;
    logic                           out_valid_reg, out_valid_next;
    bnat_pkg::out_item_t            out_item_reg, out_item_next;
    logic [bnat_pkg::ID_W-1:0]      cand_norm;
    logic [bnat_pkg::CNT_W-1:0]     eidx_ext;
    logic                           accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign eidx_ext  = bnat_pkg::CNT_W'(in_item.entry_index);

    always_comb
    begin
        cand_norm = cand_reg;
        if (cand_reg == '0 && !item_reg.search_up)
        begin
            cand_norm = bnat_pkg::ID_LAST;
        end
        else if (cand_reg == bnat_pkg::ID_BCAST && item_reg.search_up)
        begin
            cand_norm = bnat_pkg::ID_FIRST;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        vc_next        = vc_reg;
        cand_next      = cand_reg;
        drop_id_next   = drop_id_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        rid_next       = rid_reg;
        e0_id_next     = e0_id_reg;
        e0_ser_next    = e0_ser_reg;
        pnp_next       = pnp_reg;
        lid_next       = lid_reg;
        lser_next      = lser_reg;
        boot_next      = boot_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        map_req        = '0;
        tab_req        = '0;
        ent_req        = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                bnat_pkg::CFG_PNP:       pnp_next  = cfg_data[0];
                bnat_pkg::CFG_LOCAL_ID:  lid_next  = cfg_data[bnat_pkg::ID_W-1:0];
                bnat_pkg::CFG_LOCAL_SER: lser_next = cfg_data;
                default:                 ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next   = in_item;
                    status_next = bnat_pkg::ST_NONE;
                    rid_next    = '0;
                    k_next      = bnat_pkg::CNT_W'(1);
                    case (in_item.action)
                        bnat_pkg::ACT_REPORT:  state_next = S_RPT_MRD;
                        bnat_pkg::ACT_REMOVE:
                        begin
                            if (vc_reg <= bnat_pkg::CNT_W'(1) || eidx_ext >= vc_reg ||
                                eidx_ext == '0)
                            begin
                                status_next = bnat_pkg::ST_REFUSED;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                k_next     = eidx_ext;
                                state_next = S_RM_ID;
                            end
                        end
                        bnat_pkg::ACT_IDLE_ID: state_next = S_IDL_RD;
                        bnat_pkg::ACT_MSEARCH:
                        begin
                            k_next     = '0;
                            state_next = S_TCLR;
                        end
                        bnat_pkg::ACT_MCHANGE:
                        begin
                            lid_next   = in_item.target_id;
                            e0_id_next = in_item.target_id;
                            rid_next   = in_item.target_id;
                            state_next = S_MC_RD1;
                        end
                        bnat_pkg::ACT_REINIT:
                        begin
                            e0_id_next  = lid_reg;
                            e0_ser_next = lser_reg;
                            k_next      = '0;
                            state_next  = S_MCLR;
                        end
                        default:               state_next = S_DONE;
                    endcase
                end
            end
            S_RPT_MRD:
            begin
                map_req.raddr = item_reg.node_id;
                state_next    = S_RPT_MCK;
            end
            S_RPT_MCK:
            begin
                if (map_rdata[0])
                begin
                    if (e0_id_reg == item_reg.node_id)
                    begin
                        state_next = S_DONE;
                        if (e0_ser_reg != item_reg.serial_no)
                        begin
                            if (!pnp_reg)
                            begin
                                status_next = bnat_pkg::ST_REFUSED;
                            end
                            else
                            begin
                                map_req.we    = 1'b1;
                                map_req.waddr = item_reg.node_id;
                                map_req.wdata = 2'b11;
                                status_next   = bnat_pkg::ST_CONFLICT;
                            end
                        end
                    end
                    else
                    begin
                        state_next = S_RPT_ERD;
                    end
                end
                else if (vc_reg >= DEPTH_CNT)
                begin
                    status_next = bnat_pkg::ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    map_req.we            = 1'b1;
                    map_req.waddr         = item_reg.node_id;
                    map_req.wdata         = 2'b01;
                    ent_req.we            = 1'b1;
                    ent_req.waddr         = vc_reg[bnat_pkg::ID_W-1:0];
                    ent_req.wdata.node_id = item_reg.node_id;
                    ent_req.wdata.serial  = item_reg.serial_no;
                    ent_req.wdata.port    = item_reg.port;
                    vc_next               = vc_reg + bnat_pkg::CNT_W'(1);
                    status_next           = bnat_pkg::ST_INSERTED;
                    state_next            = S_DONE;
                end
            end
            S_RPT_ERD:
            begin
                if (k_reg >= vc_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ent_req.raddr = k_reg[bnat_pkg::ID_W-1:0];
                    state_next    = S_RPT_ECK;
                end
            end
            S_RPT_ECK:
            begin
                if (ent_rdata.node_id == item_reg.node_id)
                begin
                    state_next = S_DONE;
                    if (ent_rdata.serial != item_reg.serial_no)
                    begin
                        if (!pnp_reg)
                        begin
                            drop_id_next = item_reg.node_id;
                            state_next   = S_DROP;
                        end
                        else
                        begin
                            map_req.we    = 1'b1;
                            map_req.waddr = item_reg.node_id;
                            map_req.wdata = 2'b11;
                            status_next   = bnat_pkg::ST_CONFLICT;
                        end
                    end
                end
                else
                begin
                    k_next     = k_reg + bnat_pkg::CNT_W'(1);
                    state_next = S_RPT_ERD;
                end
            end
            S_RM_ID:
            begin
                ent_req.raddr = k_reg[bnat_pkg::ID_W-1:0];
                state_next    = S_DROP;
            end
            S_DROP:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = (item_reg.action == bnat_pkg::ACT_REMOVE) ?
                                ent_rdata.node_id : drop_id_reg;
                map_req.wdata = 2'b00;
                status_next   = bnat_pkg::ST_REMOVED;
                state_next    = S_SH_RD;
            end
            S_SH_RD:
            begin
                if (k_reg + bnat_pkg::CNT_W'(1) < vc_reg)
                begin
                    ent_req.raddr = k_reg[bnat_pkg::ID_W-1:0] + bnat_pkg::ID_W'(1);
                    state_next    = S_SH_WR;
                end
                else
                begin
                    vc_next    = vc_reg - bnat_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_SH_WR:
            begin
                ent_req.we    = 1'b1;
                ent_req.waddr = k_reg[bnat_pkg::ID_W-1:0];
                ent_req.wdata = ent_rdata;
                k_next        = k_reg + bnat_pkg::CNT_W'(1);
                state_next    = S_SH_RD;
            end
            S_IDL_RD:
            begin
                map_req.raddr = k_reg[bnat_pkg::ID_W-1:0];
                state_next    = S_IDL_CK;
            end
            S_IDL_CK:
            begin
                if (map_rdata == 2'b00)
                begin
                    rid_next    = k_reg[bnat_pkg::ID_W-1:0];
                    status_next = bnat_pkg::ST_NONE;
                    state_next  = S_DONE;
                end
                else if (k_reg[bnat_pkg::ID_W-1:0] == bnat_pkg::ID_LAST)
                begin
                    rid_next    = bnat_pkg::ID_NONE;
                    status_next = bnat_pkg::ST_NO_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + bnat_pkg::CNT_W'(1);
                    state_next = S_IDL_RD;
                end
            end
            S_TCLR:
            begin
                tab_req.we    = 1'b1;
                tab_req.waddr = k_reg[bnat_pkg::ID_W-1:0];
                tab_req.wdata = 1'b0;
                if (k_reg == LAST_ID_CNT)
                begin
                    k_next     = bnat_pkg::CNT_W'(1);
                    state_next = S_TMK_RD;
                end
                else
                begin
                    k_next = k_reg + bnat_pkg::CNT_W'(1);
                end
            end
            S_TMK_RD:
            begin
                if (k_reg >= vc_reg)
                begin
                    cand_next  = item_reg.target_id;
                    cnt_next   = '0;
                    state_next = S_CND_RD;
                end
                else
                begin
                    ent_req.raddr = k_reg[bnat_pkg::ID_W-1:0];
                    state_next    = S_TMK_WR;
                end
            end
            S_TMK_WR:
            begin
                tab_req.we    = 1'b1;
                tab_req.waddr = ent_rdata.node_id;
                tab_req.wdata = 1'b1;
                k_next        = k_reg + bnat_pkg::CNT_W'(1);
                state_next    = S_TMK_RD;
            end
            S_CND_RD:
            begin
                tab_req.raddr = cand_norm;
                cand_next     = cand_norm;
                state_next    = S_CND_CK;
            end
            S_CND_CK:
            begin
                if (!tab_rdata)
                begin
                    rid_next    = cand_reg;
                    status_next = bnat_pkg::ST_NONE;
                    state_next  = S_DONE;
                end
                else if (cnt_reg == CAND_LAST)
                begin
                    rid_next    = bnat_pkg::ID_NONE;
                    status_next = bnat_pkg::ST_NO_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cand_next  = item_reg.search_up ? cand_reg + bnat_pkg::ID_W'(1) :
                                                      cand_reg - bnat_pkg::ID_W'(1);
                    cnt_next   = cnt_reg + bnat_pkg::CNT_W'(1);
                    state_next = S_CND_RD;
                end
            end
            S_MC_RD1:
            begin
                map_req.raddr = item_reg.node_id;
                state_next    = S_MC_WR1;
            end
            S_MC_WR1:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = item_reg.node_id;
                map_req.wdata = {map_rdata[1], 1'b0};
                state_next    = S_MC_RD2;
            end
            S_MC_RD2:
            begin
                map_req.raddr = item_reg.target_id;
                state_next    = S_MC_WR2;
            end
            S_MC_WR2:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = item_reg.target_id;
                map_req.wdata = {map_rdata[1], 1'b1};
                state_next    = S_DONE;
            end
            S_MCLR:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = k_reg[bnat_pkg::ID_W-1:0];
                map_req.wdata = 2'b00;
                if (k_reg == LAST_ID_CNT)
                begin
                    state_next = S_MK0;
                end
                else
                begin
                    k_next = k_reg + bnat_pkg::CNT_W'(1);
                end
            end
            S_MK0:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = e0_id_reg;
                map_req.wdata = 2'b01;
                k_next        = bnat_pkg::CNT_W'(1);
                state_next    = S_MK_RD;
            end
            S_MK_RD:
            begin
                if (k_reg >= vc_reg)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_DONE;
                end
                else
                begin
                    ent_req.raddr = k_reg[bnat_pkg::ID_W-1:0];
                    state_next    = S_MK_WR;
                end
            end
            S_MK_WR:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = ent_rdata.node_id;
                map_req.wdata = 2'b01;
                k_next        = k_reg + bnat_pkg::CNT_W'(1);
                state_next    = S_MK_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.status      = status_reg;
                    out_item_next.result_id   = rid_reg;
                    out_item_next.entry_count = vc_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_MCLR;
            k_reg         <= '0;
            cnt_reg       <= '0;
            vc_reg        <= bnat_pkg::CNT_W'(1);
            e0_id_reg     <= bnat_pkg::ID_FIRST;
            e0_ser_reg    <= '0;
            pnp_reg       <= 1'b1;
            lid_reg       <= bnat_pkg::ID_FIRST;
            lser_reg      <= '0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            vc_reg        <= vc_next;
            e0_id_reg     <= e0_id_next;
            e0_ser_reg    <= e0_ser_next;
            pnp_reg       <= pnp_next;
            lid_reg       <= lid_next;
            lser_reg      <= lser_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        drop_id_reg  <= drop_id_next;
        item_reg     <= item_next;
        status_reg   <= status_next;
        rid_reg      <= rid_next;
        out_item_reg <= out_item_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg != '0 && vc_reg <= DEPTH_CNT)
        else $error("entry count out of range");

    a_entry_zero_kept: assert property (@(posedge clk) disable iff (!rst_n)
        ent_req.we |-> ent_req.waddr != '0)
        else $error("entry zero written in memory");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !map_req.we && !ent_req.we && !tab_req.we)
        else $error("memory written while idle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("second item taken while busy");

endmodule
`default_nettype wire

>>> design/bus_node_address_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bus node address table
// Node database with online and conflict bitmaps and an ordered entry table.
// ----------------------------------------------------------------------------
// One item at a time; a report may scan the entry table for the node id.
// Removal shifts the later entries down; an idle id search tries ids in turn.
// A master search clears the scratch map, marks each entry, then tries candidates.
// Reinit and reset sweep the bitmap memory, then mark each entry online again.
// After reset no item is taken while the bitmaps clear.
// ----------------------------------------------------------------------------
module bus_node_address_table_top #(
    parameter int TABLE_DEPTH = bnat_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire bnat_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output bnat_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bnat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bnat_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    bnat_pkg::map_req_t map_req;
    bnat_pkg::tab_req_t tab_req;
    bnat_pkg::ent_req_t ent_req;
    logic [1:0]         map_rdata;
    logic               tab_rdata;
    bnat_pkg::entry_t   ent_rdata;

    assign cfg_ready = 1'b1;

    bnat_ram #(
        .DW    (2),
        .DEPTH (bnat_pkg::ID_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_req.we),
        .waddr (map_req.waddr),
        .wdata (map_req.wdata),
        .raddr (map_req.raddr),
        .rdata (map_rdata)
    );

    bnat_ram #(
        .DW    (1),
        .DEPTH (bnat_pkg::ID_COUNT)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_req.we),
        .waddr (tab_req.waddr),
        .wdata (tab_req.wdata),
        .raddr (tab_req.raddr),
        .rdata (tab_rdata)
    );

    bnat_ram #(
        .DW    ($bits(bnat_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_req.we),
        .waddr (ent_req.waddr[AW-1:0]),
        .wdata (ent_req.wdata),
        .raddr (ent_req.raddr[AW-1:0]),
        .rdata (ent_rdata)
    );

    bnat_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .map_req   (map_req),
        .map_rdata (map_rdata),
        .tab_req   (tab_req),
        .tab_rdata (tab_rdata),
        .ent_req   (ent_req),
        .ent_rdata (ent_rdata)
    );

endmodule
`default_nettype wire
